// ===== src/vsc_pkg.sv =====
package vsc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] ST_NORM = 4'h0;
  localparam logic [3:0] ST_INT  = 4'h4;
  localparam logic [3:0] ST_FRAC = 4'h8;
  localparam logic [3:0] ST_ZERO = 4'hC;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_DIGIT = 2'd1;
  localparam logic [1:0] CLS_ZERO  = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_LEN
  } phase_t;

  typedef enum logic [1:0] {
    K_DIFF,
    K_LEN,
    K_POS,
    K_NEG
  } outcome_t;

  typedef struct packed {
    logic              start;
    logic [1:0]        class_a;
    logic [1:0]        class_b;
    logic              a_nonzero;
    logic signed [8:0] diff;
  } vsc_item_t;

  localparam logic [3:0] SCAN_TABLE [16] = '{
    ST_NORM, ST_INT,  ST_ZERO, ST_NORM,
    ST_NORM, ST_INT,  ST_INT,  ST_INT,
    ST_NORM, ST_FRAC, ST_FRAC, ST_FRAC,
    ST_NORM, ST_FRAC, ST_ZERO, ST_ZERO
  };

  localparam outcome_t OUTCOME_TABLE [64] = '{
    K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_LEN,  K_DIFF, K_DIFF,
    K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
    K_DIFF, K_NEG,  K_NEG,  K_DIFF, K_POS,  K_LEN,  K_LEN,  K_DIFF,
    K_POS,  K_LEN,  K_LEN,  K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
    K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_LEN,  K_DIFF, K_DIFF,
    K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
    K_DIFF, K_POS,  K_POS,  K_DIFF, K_NEG,  K_DIFF, K_DIFF, K_DIFF,
    K_NEG,  K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF
  };

  function automatic logic [1:0] char_class(input logic [7:0] c);
    logic [1:0] cls;
    if (c == CHAR_ZERO) begin
      cls = CLS_ZERO;
    end else if (c > CHAR_ZERO && c <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// ===== src/vsc_front.sv =====
module vsc_front
  import vsc_pkg::*;
(
  input  logic      start_req,
  input  logic [7:0] char_a,
  input  logic [7:0] char_b,
  output vsc_item_t item
);

  always_comb begin
    item.start     = start_req;
    item.class_a   = char_class(char_a);
    item.class_b   = char_class(char_b);
    item.a_nonzero = (char_a != 8'h00);
    item.diff      = $signed({1'b0, char_a}) - $signed({1'b0, char_b});
  end

endmodule

// ===== src/vsc_queue.sv =====
module vsc_queue
  import vsc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_stall,
  input  vsc_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_stall,
  output vsc_item_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  vsc_item_t     store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_stall = (count == CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = store[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/vsc_back.sv =====
module vsc_back
  import vsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  vsc_item_t         item,
  output logic              res_valid,
  input  logic              res_stall,
  output logic signed [8:0] order
);

  phase_t            phase;
  phase_t            phase_next;
  phase_t            phase_eff;
  logic [3:0]        scan_state;
  logic [3:0]        scan_state_next;
  logic [3:0]        scan_eff;
  logic signed [8:0] saved_difference;
  logic signed [8:0] saved_difference_next;
  logic signed [8:0] saved_eff;
  logic [3:0]        st_idx;
  outcome_t          kind;
  logic              take;
  logic              emit;
  logic signed [8:0] emit_val;
  logic              digit_a;
  logic              digit_b;

  assign item_stall = res_valid && res_stall;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      scan_state       <= ST_NORM;
      saved_difference <= '0;
    end else begin
      phase            <= phase_next;
      scan_state       <= scan_state_next;
      saved_difference <= saved_difference_next;
    end
  end

  always_comb begin
    phase_eff = item.start ? PH_SCAN : phase;
    scan_eff  = item.start ? ST_NORM : scan_state;
    saved_eff = item.start ? 9'sd0 : saved_difference;
    st_idx    = scan_eff | {2'b00, item.class_a};
    kind      = OUTCOME_TABLE[{st_idx, item.class_b}];
    digit_a   = (item.class_a != CLS_OTHER);
    digit_b   = (item.class_b != CLS_OTHER);

    phase_next            = phase;
    scan_state_next       = scan_state;
    saved_difference_next = saved_difference;
    emit                  = 1'b0;
    emit_val              = item.diff;

    if (take) begin
      phase_next            = phase_eff;
      scan_state_next       = scan_eff;
      saved_difference_next = saved_eff;
      case (phase_eff)
        PH_SCAN: begin
          if (item.diff == 9'sd0 && item.a_nonzero) begin
            scan_state_next = SCAN_TABLE[st_idx];
          end else begin
            case (kind)
              K_DIFF: begin
                emit       = 1'b1;
                emit_val   = item.diff;
                phase_next = PH_IDLE;
              end
              K_LEN: begin
                saved_difference_next = item.diff;
                phase_next            = PH_LEN;
              end
              K_POS: begin
                emit       = 1'b1;
                emit_val   = 9'sd1;
                phase_next = PH_IDLE;
              end
              default: begin
                emit       = 1'b1;
                emit_val   = -9'sd1;
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
        PH_LEN: begin
          if (digit_a) begin
            if (!digit_b) begin
              emit       = 1'b1;
              emit_val   = 9'sd1;
              phase_next = PH_IDLE;
            end
          end else begin
            emit       = 1'b1;
            emit_val   = digit_b ? -9'sd1 : saved_eff;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!item_stall) begin
      res_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      order <= emit_val;
    end
  end

endmodule

// ===== src/version_string_compare.sv =====
// Each accepted pair is stored in the queue; the result beat it decides is registered.
// Throughput: one character pair per cycle while neither the queue nor the result stalls.
// The front end classifies each pair into a small queue, so each side can stall on its own.
// Reset is synchronous and active high; it empties the queue and returns the scanner to idle.
module version_string_compare
  import vsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              start_req,
  input  logic [7:0]        char_a,
  input  logic [7:0]        char_b,
  output logic              res_valid,
  input  logic              res_stall,
  output logic signed [8:0] order
);

  vsc_item_t front_item;
  vsc_item_t q_item;
  logic      q_valid;
  logic      q_stall;

  vsc_front u_front (
    .start_req (start_req),
    .char_a    (char_a),
    .char_b    (char_b),
    .item      (front_item)
  );

  vsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_stall (req_stall),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  vsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_stall (q_stall),
    .item       (q_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .order      (order)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result beat offered right after reset.");

  a_no_source: assert property (@(posedge clk) disable iff (rst)
    (!q_valid && !(res_valid && res_stall)) |=> !res_valid)
    else $error("Result beat appeared with no queued pair behind it.");

  a_order_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (order != 9'sh100))
    else $error("Result order outside the byte difference range.");

  a_stall_tracks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> q_stall)
    else $error("Back end took a pair while its result was blocked.");
`endif

endmodule
